// ===== src/bll_pkg.sv =====
// Shared types and constants for the binary-lifting LCA engine.
// Used by every module of the block; depends on nothing.
`default_nettype none

package bll_pkg;

    localparam int NODE_W  = 10;   // node index as carried by the words
    localparam int DEPTH_W = 10;
    localparam int CNT_W   = 11;   // node_count and node counters
    localparam int LVL_W   = 4;    // level index, covers up to 16 levels
    localparam int DIFF_W  = 16;   // one bit per possible level
    localparam int EXT_W   = 17;   // wide enough to hold any MAX_NODES

    localparam int DEF_MAX_NODES = 1024;
    localparam int DEF_LEVELS    = 10;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_BUILD = 2'd1,
        OP_QUERY = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_LOAD,
        S_B_INIT,
        S_B_RD1,
        S_B_RD2,
        S_B_WR,
        S_Q_CHK_P,
        S_Q_CHK_Q,
        S_Q_DEPTH,
        S_Q_ORDER,
        S_Q_DIFF,
        S_LIFT,
        S_LIFT_WAIT,
        S_Q_EQ,
        S_BOTH_Q,
        S_BOTH_CMP,
        S_FINAL,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [1:0]         operation;
        logic [NODE_W-1:0]  node;
        logic [NODE_W-1:0]  parent_node;
        logic [DEPTH_W-1:0] node_depth;
        logic [NODE_W-1:0]  other_node;
    } in_word_t;

    typedef struct packed {
        logic [NODE_W-1:0] ancestor;
        logic              error;
    } out_word_t;

    // Port requests from the sequencer to the tables.
    typedef struct packed {
        logic               anc_rd;
        logic [NODE_W-1:0]  anc_rd_node;
        logic [LVL_W-1:0]   anc_rd_lvl;
        logic               anc_wr;
        logic [NODE_W-1:0]  anc_wr_node;
        logic [LVL_W-1:0]   anc_wr_lvl;
        logic [NODE_W-1:0]  anc_wr_data;
        logic               dep_rd;
        logic [NODE_W-1:0]  dep_rd_node;
        logic               dep_wr;
        logic [NODE_W-1:0]  dep_wr_node;
        logic [DEPTH_W-1:0] dep_wr_data;
    } tbl_req_t;

    typedef struct packed {
        logic             eq;
        logic             lt;
        logic [CNT_W-1:0] diff;
    } alu_res_t;

    typedef struct packed {
        logic busy;
        logic res_valid;
    } ctrl_stat_t;

endpackage

`default_nettype wire

// ===== src/bll_alu.sv =====
// Shared compare / subtract unit of the LCA sequencer.
// Depends on bll_pkg.
`default_nettype none

module bll_alu
    import bll_pkg::*;
(
    input  wire logic [CNT_W-1:0] a,
    input  wire logic [CNT_W-1:0] b,
    output alu_res_t              res
);

    always_comb
    begin
        res.eq   = (a == b);
        res.lt   = (a < b);
        res.diff = a - b;
    end

endmodule

`default_nettype wire

// ===== src/bll_tables.sv =====
// Ancestor table and depth store, one write and one registered read port each.
// Depends on bll_pkg.
`default_nettype none

module bll_tables
    import bll_pkg::*;
#(
    parameter int MAX_NODES = DEF_MAX_NODES,
    parameter int LEVELS    = DEF_LEVELS
)
(
    input  wire logic               clk,
    input  wire tbl_req_t           req,
    output logic [NODE_W-1:0]       anc_rdata,
    output logic [DEPTH_W-1:0]      dep_rdata
);

    localparam int ADDR_W    = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int LA_W      = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int ANC_DEPTH = MAX_NODES * (1 << LA_W);

    logic [NODE_W-1:0]  anc_mem [ANC_DEPTH];
    logic [DEPTH_W-1:0] dep_mem [MAX_NODES];

    logic [NODE_W-1:0]  anc_q_reg;
    logic               anc_oob_reg;
    logic [DEPTH_W-1:0] dep_q_reg;
    logic               dep_oob_reg;

    function automatic logic [ADDR_W-1:0] node_addr(input logic [NODE_W-1:0] n);
        logic [EXT_W-1:0] ext;
        ext = EXT_W'(n);
        return ext[ADDR_W-1:0];
    endfunction

    function automatic logic in_store(input logic [NODE_W-1:0] n);
        return EXT_W'(n) < EXT_W'(MAX_NODES);
    endfunction

    always_ff @(posedge clk)
    begin
        if (req.anc_wr && in_store(req.anc_wr_node))
        begin
            anc_mem[{node_addr(req.anc_wr_node), req.anc_wr_lvl[LA_W-1:0]}] <= req.anc_wr_data;
        end
        if (req.anc_rd)
        begin
            anc_q_reg   <= anc_mem[{node_addr(req.anc_rd_node), req.anc_rd_lvl[LA_W-1:0]}];
            anc_oob_reg <= !in_store(req.anc_rd_node);
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.dep_wr && in_store(req.dep_wr_node))
        begin
            dep_mem[node_addr(req.dep_wr_node)] <= req.dep_wr_data;
        end
        if (req.dep_rd)
        begin
            dep_q_reg   <= dep_mem[node_addr(req.dep_rd_node)];
            dep_oob_reg <= !in_store(req.dep_rd_node);
        end
    end

    // a node beyond storage reads back as ancestor 0, depth 0
    assign anc_rdata = anc_oob_reg ? '0 : anc_q_reg;
    assign dep_rdata = dep_oob_reg ? '0 : dep_q_reg;

endmodule

`default_nettype wire

// ===== src/bll_ctrl.sv =====
// Sequencer for load, build and query words, driving the shared ALU and tables.
// Depends on bll_pkg and bll_alu.
`default_nettype none

module bll_ctrl
    import bll_pkg::*;
#(
    parameter int MAX_NODES = DEF_MAX_NODES,
    parameter int LEVELS    = DEF_LEVELS
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire in_word_t           item,
    input  wire logic [CNT_W-1:0]   node_count,
    input  wire logic               out_free,
    input  wire logic [NODE_W-1:0]  anc_rdata,
    input  wire logic [DEPTH_W-1:0] dep_rdata,
    output tbl_req_t                req,
    output ctrl_stat_t              stat,
    output out_word_t               res_word
);

    localparam logic [LVL_W-1:0] TOP_LVL = LVL_W'(LEVELS - 1);

    state_t              state_reg, state_next;
    in_word_t            item_reg, item_next;
    logic [NODE_W-1:0]   p_reg, p_next;
    logic [NODE_W-1:0]   q_reg, q_next;
    logic [NODE_W-1:0]   ap_reg, ap_next;
    logic [DEPTH_W-1:0]  dp_reg, dp_next;
    logic [DEPTH_W-1:0]  dq_reg, dq_next;
    logic [DIFF_W-1:0]   diff_reg, diff_next;
    logic [LVL_W-1:0]    lvl_reg, lvl_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [NODE_W-1:0]   res_anc_reg, res_anc_next;
    logic                res_err_reg, res_err_next;

    logic [CNT_W-1:0]    limit;
    logic [CNT_W-1:0]    alu_a;
    logic [CNT_W-1:0]    alu_b;
    alu_res_t            alu_res;
    logic [NODE_W-1:0]   pn;
    logic [NODE_W-1:0]   qn;

    bll_alu u_alu
    (
        .a   (alu_a),
        .b   (alu_b),
        .res (alu_res)
    );

    always_comb
    begin
        if (EXT_W'(node_count) < EXT_W'(MAX_NODES))
            limit = node_count;
        else
            limit = CNT_W'(MAX_NODES);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        item_reg    <= item_next;
        p_reg       <= p_next;
        q_reg       <= q_next;
        ap_reg      <= ap_next;
        dp_reg      <= dp_next;
        dq_reg      <= dq_next;
        diff_reg    <= diff_next;
        lvl_reg     <= lvl_next;
        cnt_reg     <= cnt_next;
        res_anc_reg <= res_anc_next;
        res_err_reg <= res_err_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        item_next    = item_reg;
        p_next       = p_reg;
        q_next       = q_reg;
        ap_next      = ap_reg;
        dp_next      = dp_reg;
        dq_next      = dq_reg;
        diff_next    = diff_reg;
        lvl_next     = lvl_reg;
        cnt_next     = cnt_reg;
        res_anc_next = res_anc_reg;
        res_err_next = res_err_reg;
        req          = '0;
        stat.busy      = (state_reg != S_IDLE);
        stat.res_valid = 1'b0;
        alu_a        = '0;
        alu_b        = '0;
        pn           = p_reg;
        qn           = q_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    item_next = item;
                    p_next    = item.node;
                    q_next    = item.other_node;
                    case (op_t'(item.operation))
                        OP_LOAD:  state_next = S_LOAD;
                        OP_BUILD: state_next = S_B_INIT;
                        OP_QUERY: state_next = S_Q_CHK_P;
                        default:  state_next = S_IDLE;
                    endcase
                end
            end

            S_LOAD:
            begin
                req.anc_wr      = 1'b1;
                req.anc_wr_node = item_reg.node;
                req.anc_wr_lvl  = '0;
                req.anc_wr_data = item_reg.parent_node;
                req.dep_wr      = 1'b1;
                req.dep_wr_node = item_reg.node;
                req.dep_wr_data = item_reg.node_depth;
                state_next      = S_IDLE;
            end

            S_B_INIT:
            begin
                lvl_next = LVL_W'(1);
                cnt_next = '0;
                if (LEVELS < 2 || limit == '0)
                    state_next = S_IDLE;
                else
                    state_next = S_B_RD1;
            end

            S_B_RD1:
            begin
                req.anc_rd      = 1'b1;
                req.anc_rd_node = cnt_reg[NODE_W-1:0];
                req.anc_rd_lvl  = lvl_reg - LVL_W'(1);
                state_next      = S_B_RD2;
            end

            S_B_RD2:
            begin
                req.anc_rd      = 1'b1;
                req.anc_rd_node = anc_rdata;
                req.anc_rd_lvl  = lvl_reg - LVL_W'(1);
                state_next      = S_B_WR;
            end

            S_B_WR:
            begin
                req.anc_wr      = 1'b1;
                req.anc_wr_node = cnt_reg[NODE_W-1:0];
                req.anc_wr_lvl  = lvl_reg;
                req.anc_wr_data = anc_rdata;
                state_next      = S_B_RD1;
                if ((cnt_reg + CNT_W'(1)) == limit)
                begin
                    cnt_next = '0;
                    if (lvl_reg == TOP_LVL)
                        state_next = S_IDLE;
                    else
                        lvl_next = lvl_reg + LVL_W'(1);
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end

            S_Q_CHK_P:
            begin
                alu_a           = {1'b0, p_reg};
                alu_b           = limit;
                req.dep_rd      = 1'b1;
                req.dep_rd_node = p_reg;
                if (!alu_res.lt)
                begin
                    res_anc_next = '0;
                    res_err_next = 1'b1;
                    state_next   = S_DONE;
                end
                else
                begin
                    state_next = S_Q_CHK_Q;
                end
            end

            S_Q_CHK_Q:
            begin
                alu_a           = {1'b0, q_reg};
                alu_b           = limit;
                req.dep_rd      = 1'b1;
                req.dep_rd_node = q_reg;
                dp_next         = dep_rdata;
                if (!alu_res.lt)
                begin
                    res_anc_next = '0;
                    res_err_next = 1'b1;
                    state_next   = S_DONE;
                end
                else
                begin
                    state_next = S_Q_DEPTH;
                end
            end

            S_Q_DEPTH:
            begin
                dq_next    = dep_rdata;
                state_next = S_Q_ORDER;
            end

            S_Q_ORDER:
            begin
                // deeper node goes to p
                alu_a = {1'b0, dp_reg};
                alu_b = {1'b0, dq_reg};
                if (alu_res.lt)
                begin
                    p_next  = q_reg;
                    q_next  = p_reg;
                    dp_next = dq_reg;
                    dq_next = dp_reg;
                end
                state_next = S_Q_DIFF;
            end

            S_Q_DIFF:
            begin
                alu_a      = {1'b0, dp_reg};
                alu_b      = {1'b0, dq_reg};
                diff_next  = DIFF_W'(alu_res.diff[DEPTH_W-1:0]);
                lvl_next   = TOP_LVL;
                state_next = S_LIFT;
            end

            S_LIFT:
            begin
                if (diff_reg[lvl_reg])
                begin
                    req.anc_rd      = 1'b1;
                    req.anc_rd_node = p_reg;
                    req.anc_rd_lvl  = lvl_reg;
                    state_next      = S_LIFT_WAIT;
                end
                else if (lvl_reg == '0)
                begin
                    state_next = S_Q_EQ;
                end
                else
                begin
                    lvl_next = lvl_reg - LVL_W'(1);
                end
            end

            S_LIFT_WAIT:
            begin
                p_next = anc_rdata;
                if (lvl_reg == '0)
                begin
                    state_next = S_Q_EQ;
                end
                else
                begin
                    lvl_next   = lvl_reg - LVL_W'(1);
                    state_next = S_LIFT;
                end
            end

            S_Q_EQ:
            begin
                alu_a = {1'b0, p_reg};
                alu_b = {1'b0, q_reg};
                if (alu_res.eq)
                begin
                    res_anc_next = p_reg;
                    res_err_next = 1'b0;
                    state_next   = S_DONE;
                end
                else
                begin
                    lvl_next        = TOP_LVL;
                    req.anc_rd      = 1'b1;
                    req.anc_rd_node = p_reg;
                    req.anc_rd_lvl  = TOP_LVL;
                    state_next      = S_BOTH_Q;
                end
            end

            S_BOTH_Q:
            begin
                ap_next         = anc_rdata;
                req.anc_rd      = 1'b1;
                req.anc_rd_node = q_reg;
                req.anc_rd_lvl  = lvl_reg;
                state_next      = S_BOTH_CMP;
            end

            S_BOTH_CMP:
            begin
                // lift both where their ancestors differ, then fetch p's next one
                alu_a = {1'b0, ap_reg};
                alu_b = {1'b0, anc_rdata};
                if (!alu_res.eq)
                begin
                    pn = ap_reg;
                    qn = anc_rdata;
                end
                p_next          = pn;
                q_next          = qn;
                req.anc_rd      = 1'b1;
                req.anc_rd_node = pn;
                if (lvl_reg == '0)
                begin
                    req.anc_rd_lvl = '0;
                    state_next     = S_FINAL;
                end
                else
                begin
                    req.anc_rd_lvl = lvl_reg - LVL_W'(1);
                    lvl_next       = lvl_reg - LVL_W'(1);
                    state_next     = S_BOTH_Q;
                end
            end

            S_FINAL:
            begin
                res_anc_next = anc_rdata;
                res_err_next = 1'b0;
                state_next   = S_DONE;
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    stat.res_valid = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign res_word.ancestor = res_anc_reg;
    assign res_word.error    = res_err_reg;

endmodule

`default_nettype wire

// ===== src/binary_lifting_lca.sv =====
// Top level of the binary-lifting LCA engine: config register, sequencer,
// tables and result register. Depends on bll_pkg, bll_ctrl, bll_tables.
//
//   channel | direction | handshake           | word
//   cfg     | in        | cfg_valid/cfg_ready | cfg_data (node_count)
//   req     | in        | req_valid/req_stall | req_word (in_word_t)
//   rsp     | out       | rsp_valid/rsp_stall | rsp_word (out_word_t)
//
// One word at a time; req_stall is high while a word is in work.
// Build and query are paced by the single ancestor table read port.
// A finished result sits in the output register; the sequencer only waits
// if a second result is ready before the first is taken.
// Reset clears control state; table contents are undefined until loaded.
`default_nettype none

module binary_lifting_lca
    import bll_pkg::*;
#(
    parameter int MAX_NODES = DEF_MAX_NODES,
    parameter int LEVELS    = DEF_LEVELS
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [CNT_W-1:0] cfg_data,
    input  wire logic             req_valid,
    output logic                  req_stall,
    input  wire in_word_t         req_word,
    output logic                  rsp_valid,
    input  wire logic             rsp_stall,
    output out_word_t             rsp_word
);

    logic [CNT_W-1:0]   node_count_reg;
    logic               rsp_valid_reg, rsp_valid_next;
    out_word_t          rsp_word_reg, rsp_word_next;

    tbl_req_t           tbl_req;
    ctrl_stat_t         stat;
    out_word_t          res_word;
    logic [NODE_W-1:0]  anc_rdata;
    logic [DEPTH_W-1:0] dep_rdata;
    logic               start;
    logic               out_free;

    assign cfg_ready = 1'b1;
    assign req_stall = stat.busy;
    assign start     = req_valid && !req_stall;
    assign out_free  = !rsp_valid_reg || !rsp_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            node_count_reg <= CNT_W'(1);
        else if (cfg_valid && cfg_ready)
            node_count_reg <= cfg_data;
    end

    bll_ctrl #(
        .MAX_NODES (MAX_NODES),
        .LEVELS    (LEVELS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .item       (req_word),
        .node_count (node_count_reg),
        .out_free   (out_free),
        .anc_rdata  (anc_rdata),
        .dep_rdata  (dep_rdata),
        .req        (tbl_req),
        .stat       (stat),
        .res_word   (res_word)
    );

    bll_tables #(
        .MAX_NODES (MAX_NODES),
        .LEVELS    (LEVELS)
    ) u_tables (
        .clk       (clk),
        .req       (tbl_req),
        .anc_rdata (anc_rdata),
        .dep_rdata (dep_rdata)
    );

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_word_next  = rsp_word_reg;
        if (stat.res_valid)
        begin
            rsp_valid_next = 1'b1;
            rsp_word_next  = res_word;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else
            rsp_valid_reg <= rsp_valid_next;
    end

    always_ff @(posedge clk)
    begin
        rsp_word_reg <= rsp_word_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_word_reg;

endmodule

`default_nettype wire

// ===== src/bll_checker.sv =====
// Port-level checks on the LCA engine, bound to the top level.
// Depends on bll_pkg.
`default_nettype none

module bll_checker
    import bll_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             cfg_valid,
    input wire logic             cfg_ready,
    input wire logic [CNT_W-1:0] cfg_data,
    input wire logic             req_valid,
    input wire logic             req_stall,
    input wire in_word_t         req_word,
    input wire logic             rsp_valid,
    input wire logic             rsp_stall,
    input wire out_word_t        rsp_word
);

    // a held result word keeps its value
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
        else $error("result word changed while stalled");

    // any real operation raises req_stall in the cycle after it is accepted
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && (req_word.operation != OP_NONE) |=> req_stall)
        else $error("block ready straight after accepting a word");

    // an error result carries ancestor zero
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_word.error |-> rsp_word.ancestor == '0)
        else $error("error result with non-zero ancestor");

    // a fresh result is only produced while a word was in work
    a_rsp_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_stall))
        else $error("result appeared with no word in work");

endmodule

bind binary_lifting_lca bll_checker u_bll_checker (.*);

`default_nettype wire
